/* sv/pbct_pkg.sv */
// ----------------------------------------------------------------------------
// pbct_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the palette brightness/contrast table.
// ----------------------------------------------------------------------------
package pbct_pkg;

    localparam int MAX_COLORS = 256;
    localparam int MAX_GROUPS = 4;
    localparam int TOTAL_MAX  = MAX_COLORS * MAX_GROUPS;
    localparam int BANK_WORDS = (TOTAL_MAX + 31) / 32;

    localparam logic [15:0] ONE_Q12   = 16'd4096;
    localparam logic [10:0] RST_LIVE_MAX = 11'(MAX_COLORS - 1);

    localparam logic ADDR_NUM_COLORS = 1'b0;
    localparam logic ADDR_NUM_GROUPS = 1'b1;

    typedef enum logic [2:0] {
        OP_SET_COLOR   = 3'd0,
        OP_ENTRY_CON   = 3'd1,
        OP_GROUP_BRI   = 3'd2,
        OP_GROUP_CON   = 3'd3,
        OP_READ_ADJ    = 3'd4,
        OP_READ_RAW    = 3'd5,
        OP_TAKE_DIRTY  = 3'd6,
        OP_READ_DIRTY  = 3'd7
    } op_t;

    typedef struct packed {
        logic       capture;
        logic       clear_wr;
        logic       check;
        logic       ref_active;
        logic       ref_mul;
        logic       ref_sum;
        logic       ref_wr;
        logic [9:0] count;
    } pbct_cmd_t;

    typedef struct packed {
        logic loop_start;
        logic loop_last;
    } pbct_sts_t;

endpackage

/* sv/pbct_ctrl.sv */
// ----------------------------------------------------------------------------
// pbct_ctrl
// Sequencer: clearing pass, request lookup/check and per-entry refresh loop.
// ----------------------------------------------------------------------------
module pbct_ctrl
    import pbct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  pbct_sts_t sts,
    output pbct_cmd_t cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_LOOKUP  = 8'b0000_0100,
        ST_CHECK   = 8'b0000_1000,
        ST_REF_RD  = 8'b0001_0000,
        ST_REF_MUL = 8'b0010_0000,
        ST_REF_SUM = 8'b0100_0000,
        ST_REF_WR  = 8'b1000_0000
    } state_t;

    localparam logic [9:0] CLEAR_LAST = 10'(TOTAL_MAX - 1);

    state_t     state_reg, state_next;
    logic [9:0] count_reg, count_next;
    logic       done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                count_next = count_reg + 10'd1;
                if (count_reg == CLEAR_LAST)
                begin
                    state_next = ST_IDLE;
                    count_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                count_next = '0;
                if (sts.loop_start)
                begin
                    state_next = ST_REF_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_REF_RD:
            begin
                state_next = ST_REF_MUL;
            end
            ST_REF_MUL:
            begin
                state_next = ST_REF_SUM;
            end
            ST_REF_SUM:
            begin
                state_next = ST_REF_WR;
            end
            ST_REF_WR:
            begin
                if (sts.loop_last)
                begin
                    state_next = ST_IDLE;
                    count_next = '0;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_REF_RD;
                    count_next = count_reg + 10'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.capture    = (state_reg == ST_IDLE) && start;
        cmd.clear_wr   = (state_reg == ST_CLEAR);
        cmd.check      = (state_reg == ST_CHECK);
        cmd.ref_active = (state_reg == ST_REF_RD) || (state_reg == ST_REF_MUL) ||
                         (state_reg == ST_REF_SUM) || (state_reg == ST_REF_WR);
        cmd.ref_mul    = (state_reg == ST_REF_MUL);
        cmd.ref_sum    = (state_reg == ST_REF_SUM);
        cmd.ref_wr     = (state_reg == ST_REF_WR);
        cmd.count      = count_reg;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

/* sv/pbct_datapath.sv */
// ----------------------------------------------------------------------------
// pbct_datapath
// Palette stores, adjust arithmetic, dirty bitmaps and result registers.
// ----------------------------------------------------------------------------
module pbct_datapath
    import pbct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pbct_cmd_t          cmd,
    output pbct_sts_t          sts,
    input  logic [8:0]         num_colors,
    input  logic [2:0]         num_groups,
    input  logic [2:0]         operation,
    input  logic [9:0]         entry_index,
    input  logic [1:0]         group_index,
    input  logic [23:0]        color_value,
    input  logic [15:0]        contrast_value,
    input  logic signed [12:0] brightness_value,
    output logic [23:0]        color_out,
    output logic [14:0]        rgb15_out,
    output logic [31:0]        dirty_word,
    output logic [10:0]        dirty_min,
    output logic [9:0]         dirty_max,
    output logic               dirty_any
);

    function automatic logic [7:0] scale_ch(input logic [7:0] ch, input logic [31:0] c,
                                            input logic signed [12:0] b);
        logic [39:0]        p;
        logic signed [41:0] s;
        logic [17:0]        q;
        logic [7:0]         r;
        p = 40'(ch) * 40'(c);
        s = $signed({2'b00, p}) + ($signed({{29{b[12]}}, b}) <<< 20);
        q = s[41:24];
        if (s[41])
            r = 8'd0;
        else if (q > 18'd255)
            r = 8'hFF;
        else
            r = q[7:0];
        return r;
    endfunction

    // captured request
    op_t               op_reg;
    logic [9:0]        ei_reg;
    logic [1:0]        gi_reg;
    logic [23:0]       color_reg;
    logic [15:0]       con_reg;
    logic signed [12:0] bri_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op_t'(operation);
            ei_reg    <= entry_index;
            gi_reg    <= group_index;
            color_reg <= color_value;
            con_reg   <= contrast_value;
            bri_reg   <= brightness_value;
        end
    end

    // effective sizes
    logic [8:0]  nc;
    logic [2:0]  ng;
    logic [10:0] total;

    always_comb
    begin
        priority if (num_colors == 9'd0)
            nc = 9'd1;
        else if (num_colors > 9'(MAX_COLORS))
            nc = 9'(MAX_COLORS);
        else
            nc = num_colors;
        priority if (num_groups == 3'd0)
            ng = 3'd1;
        else if (num_groups > 3'(MAX_GROUPS))
            ng = 3'(MAX_GROUPS);
        else
            ng = num_groups;
    end

    assign total = 11'(nc) * 11'(ng);

    // refresh addressing
    logic        entry_op;
    logic [1:0]  ref_g;
    logic [7:0]  ref_i;
    logic [10:0] idx;

    assign entry_op = (op_reg == OP_SET_COLOR) || (op_reg == OP_ENTRY_CON);
    assign ref_g    = entry_op ? cmd.count[1:0] : gi_reg;
    assign ref_i    = entry_op ? ei_reg[7:0] : cmd.count[7:0];
    assign idx      = 11'(ref_g) * 11'(nc) + 11'(ref_i);

    // raw colors and entry contrasts, initialized by the clearing pass
    logic [23:0]           raw_mem [MAX_COLORS];
    logic [15:0]           ec_mem  [MAX_COLORS];
    logic [23:0]           raw_rd_reg;
    logic [15:0]           ec_rd_reg;
    logic [7:0]            ent_addr;
    logic [23:0]           raw_eff;
    logic [15:0]           ec_eff;

    assign ent_addr = cmd.ref_active ? ref_i : ei_reg[7:0];
    assign raw_eff  = raw_rd_reg;
    assign ec_eff   = ec_rd_reg;

    // group settings
    logic signed [12:0] gb_reg [MAX_GROUPS];
    logic [15:0]        gc_reg [MAX_GROUPS];

    // change detection
    logic in_e;
    logic in_g;
    logic loop_start;

    assign in_e = ei_reg < 10'(nc);
    assign in_g = 3'(gi_reg) < ng;

    always_comb
    begin
        unique case (op_reg)
            OP_SET_COLOR: loop_start = in_e && (raw_eff != color_reg);
            OP_ENTRY_CON: loop_start = in_e && (ec_eff != con_reg);
            OP_GROUP_BRI: loop_start = in_g && (gb_reg[gi_reg] != bri_reg);
            OP_GROUP_CON: loop_start = in_g && (gc_reg[gi_reg] != con_reg);
            default:      loop_start = 1'b0;
        endcase
    end

    assign sts.loop_start = loop_start;
    assign sts.loop_last  = entry_op ? (cmd.count == 10'(ng) - 10'd1)
                                     : (cmd.count == 10'(nc) - 10'd1);

    always_ff @(posedge clk)
    begin
        raw_rd_reg <= raw_mem[ent_addr];
        ec_rd_reg  <= ec_mem[ent_addr];
        if (cmd.clear_wr)
        begin
            raw_mem[cmd.count[7:0]] <= '0;
            ec_mem[cmd.count[7:0]]  <= ONE_Q12;
        end
        else
        begin
            if (cmd.check && loop_start && (op_reg == OP_SET_COLOR))
                raw_mem[ei_reg[7:0]] <= color_reg;
            if (cmd.check && loop_start && (op_reg == OP_ENTRY_CON))
                ec_mem[ei_reg[7:0]] <= con_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_GROUPS; k++)
            begin
                gb_reg[k] <= '0;
                gc_reg[k] <= ONE_Q12;
            end
        end
        else
        begin
            if (cmd.check && loop_start)
            begin
                unique case (op_reg)
                    OP_GROUP_BRI: gb_reg[gi_reg] <= bri_reg;
                    OP_GROUP_CON: gc_reg[gi_reg] <= con_reg;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // adjust arithmetic
    logic [31:0] c_reg;
    logic [23:0] adj_new_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ref_mul)
            c_reg <= 32'(gc_reg[ref_g]) * 32'(ec_eff);
        if (cmd.ref_sum)
        begin
            adj_new_reg <= {scale_ch(raw_eff[23:16], c_reg, gb_reg[ref_g]),
                            scale_ch(raw_eff[15:8],  c_reg, gb_reg[ref_g]),
                            scale_ch(raw_eff[7:0],   c_reg, gb_reg[ref_g])};
        end
    end

    // adjusted colors
    logic [23:0] adj_mem [TOTAL_MAX];
    logic [14:0] rgb_mem [TOTAL_MAX];
    logic [23:0] adj_rd_reg;
    logic [14:0] rgb_rd_reg;
    logic [9:0]  adj_addr;
    logic        adj_we;
    logic [14:0] rgb_new;

    assign adj_addr = cmd.ref_active ? idx[9:0] : ei_reg;
    assign adj_we   = cmd.ref_wr && (adj_new_reg != adj_rd_reg);
    assign rgb_new  = {adj_new_reg[23:19], adj_new_reg[15:11], adj_new_reg[7:3]};

    always_ff @(posedge clk)
    begin
        adj_rd_reg <= adj_mem[adj_addr];
        rgb_rd_reg <= rgb_mem[adj_addr];
        if (cmd.clear_wr)
        begin
            adj_mem[cmd.count] <= '0;
            rgb_mem[cmd.count] <= '0;
        end
        else if (adj_we)
        begin
            adj_mem[idx[9:0]] <= adj_new_reg;
            rgb_mem[idx[9:0]] <= rgb_new;
        end
    end

    // dirty bitmaps
    logic [31:0]             dmem [2*BANK_WORDS];
    logic [2*BANK_WORDS-1:0] d_vld_reg;
    logic [1:0]              fill_reg;
    logic [31:0]             d_rd_reg;
    logic                    d_vld_rd_reg;
    logic                    d_fill_rd_reg;
    logic                    live_bank_reg;
    logic [10:0]             live_min_reg;
    logic [10:0]             live_max_reg;
    logic [5:0]              d_addr;
    logic [31:0]             d_eff;
    logic                    take;

    assign d_addr = cmd.ref_active ? {live_bank_reg, idx[9:5]} : {~live_bank_reg, ei_reg[4:0]};
    assign d_eff  = d_vld_rd_reg ? d_rd_reg : {32{d_fill_rd_reg}};
    assign take   = cmd.check && (op_reg == OP_TAKE_DIRTY) && (live_min_reg <= live_max_reg);

    always_ff @(posedge clk)
    begin
        d_rd_reg <= dmem[d_addr];
        if (adj_we)
            dmem[d_addr] <= d_eff | (32'd1 << idx[4:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg     <= '0;
            fill_reg      <= '1;
            d_vld_rd_reg  <= 1'b0;
            d_fill_rd_reg <= 1'b1;
            live_bank_reg <= 1'b0;
            live_min_reg  <= '0;
            live_max_reg  <= RST_LIVE_MAX;
        end
        else
        begin
            d_vld_rd_reg  <= d_vld_reg[d_addr];
            d_fill_rd_reg <= fill_reg[d_addr[5]];
            if (adj_we)
            begin
                d_vld_reg[d_addr] <= 1'b1;
                if (idx < live_min_reg)
                    live_min_reg <= idx;
                if (idx > live_max_reg)
                    live_max_reg <= idx;
            end
            else if (take)
            begin
                live_bank_reg <= ~live_bank_reg;
                fill_reg[~live_bank_reg] <= 1'b0;
                if (live_bank_reg)
                    d_vld_reg[BANK_WORDS-1:0] <= '0;
                else
                    d_vld_reg[2*BANK_WORDS-1:BANK_WORDS] <= '0;
                live_min_reg <= total;
                live_max_reg <= '0;
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            color_out  <= '0;
            rgb15_out  <= '0;
            dirty_word <= '0;
            dirty_min  <= '0;
            dirty_max  <= '0;
            dirty_any  <= 1'b0;
            unique case (op_reg)
                OP_READ_ADJ:
                begin
                    if ({1'b0, ei_reg} < total)
                    begin
                        color_out <= adj_rd_reg;
                        rgb15_out <= rgb_rd_reg;
                    end
                end
                OP_READ_RAW:
                begin
                    if (in_e)
                        color_out <= raw_eff;
                end
                OP_TAKE_DIRTY:
                begin
                    dirty_min <= live_min_reg;
                    dirty_max <= live_max_reg[9:0];
                    dirty_any <= take;
                end
                OP_READ_DIRTY:
                begin
                    if (ei_reg < 10'(BANK_WORDS))
                        dirty_word <= d_eff;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* sv/palette_brightness_contrast_table.sv */
// ----------------------------------------------------------------------------
// palette_brightness_contrast_table
// Palette with per-entry contrast and per-group brightness/contrast, adjusted and
// RGB15 copies, and double-buffered dirty tracking.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Reads, take-dirty
// and unchanged or out-of-range sets end at the check state. A set that
// changes a color or entry contrast refreshes one adjusted entry per group,
// a changed group setting one entry per color: one refresh loop updates the
// adjusted entries one at a time through read, multiply, sum and write states.
// After reset busy stays high while the palette memories are cleared. done is
// high for one cycle and cannot be stalled; results hold until the next check.
module palette_brightness_contrast_table
    import pbct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [2:0]         operation,
    input  logic [9:0]         entry_index,
    input  logic [1:0]         group_index,
    input  logic [23:0]        color_value,
    input  logic [15:0]        contrast_value,
    input  logic signed [12:0] brightness_value,
    output logic [23:0]        color_out,
    output logic [14:0]        rgb15_out,
    output logic [31:0]        dirty_word,
    output logic [10:0]        dirty_min,
    output logic [9:0]         dirty_max,
    output logic               dirty_any,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [8:0] num_colors_reg;
    logic [2:0] num_groups_reg;
    logic       wr_en;
    pbct_cmd_t  cmd;
    pbct_sts_t  sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_colors_reg <= 9'(MAX_COLORS);
            num_groups_reg <= 3'd1;
        end
        else if (wr_en)
        begin
            if (paddr[2] == ADDR_NUM_COLORS)
                num_colors_reg <= pwdata[8:0];
            else
                num_groups_reg <= pwdata[2:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_NUM_GROUPS) ? {29'd0, num_groups_reg}
                                                  : {23'd0, num_colors_reg};

    pbct_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pbct_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .num_colors       (num_colors_reg),
        .num_groups       (num_groups_reg),
        .operation        (operation),
        .entry_index      (entry_index),
        .group_index      (group_index),
        .color_value      (color_value),
        .contrast_value   (contrast_value),
        .brightness_value (brightness_value),
        .color_out        (color_out),
        .rgb15_out        (rgb15_out),
        .dirty_word       (dirty_word),
        .dirty_min        (dirty_min),
        .dirty_max        (dirty_max),
        .dirty_any        (dirty_any)
    );

endmodule
